>>> sv/bspl_pkg.sv
// Shared types and constants for the BSP point leaf locator.
// Opcodes, field widths, table entry layouts and default sizes.
// No dependencies.
package bspl_pkg;

    localparam int IDX_W   = 13;
    localparam int NORM_W  = 16;
    localparam int COORD_W = 32;
    localparam int LEAF_W  = 12;
    localparam int STEPS_W = 7;
    localparam int OP_W    = 2;

    localparam int PROD_W    = NORM_W + COORD_W;
    localparam int DIST_W    = PROD_W + 2;
    localparam int OFF_SHIFT = 14;

    localparam int DEF_NODE_COUNT  = 4096;
    localparam int DEF_PLANE_COUNT = 8192;
    localparam int DEF_LEAF_COUNT  = 4096;
    localparam int DEF_MAX_DEPTH   = 64;

    localparam logic [OP_W-1:0] OP_NODE_WR  = 2'd0;
    localparam logic [OP_W-1:0] OP_PLANE_WR = 2'd1;
    localparam logic [OP_W-1:0] OP_LOCATE   = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE     = 2'd3;

    typedef struct packed {
        logic [IDX_W-1:0] plane;
        logic [IDX_W-1:0] front;
        logic [IDX_W-1:0] back;
    } node_entry_t;

    typedef struct packed {
        logic [NORM_W-1:0]  nx;
        logic [NORM_W-1:0]  ny;
        logic [NORM_W-1:0]  nz;
        logic [COORD_W-1:0] offset;
    } plane_entry_t;

endpackage

>>> sv/bsp_point_leaf_locator_top.sv
// Top level of the BSP point leaf locator: node and plane tables, walk sequencer.
// Depends on bspl_pkg and bspl_dist.
//
// Node and plane writes give no result word. A locate walks the tree from node 0 one
// node at a time and gives one result word. Each node takes one node table read, one
// plane table read (both synchronous memories, the second addressed by the first) and
// a pass through the three-stage distance pipeline up to the branch decision. At the
// end of its walk a locate hands its result to the output register, which can hold it
// while the next word is taken in. The input is stalled during a walk. The tables come
// up undefined after reset and need no clearing time.
module bsp_point_leaf_locator_top
    import bspl_pkg::*;
#(
    parameter int NODE_COUNT  = DEF_NODE_COUNT,
    parameter int PLANE_COUNT = DEF_PLANE_COUNT,
    parameter int LEAF_COUNT  = DEF_LEAF_COUNT,
    parameter int MAX_DEPTH   = DEF_MAX_DEPTH
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [OP_W-1:0]           opcode,
    input  logic [IDX_W-1:0]          entry_index,
    input  logic [IDX_W-1:0]          plane_ref,
    input  logic signed [IDX_W-1:0]   front_child,
    input  logic signed [IDX_W-1:0]   back_child,
    input  logic signed [NORM_W-1:0]  normal_x,
    input  logic signed [NORM_W-1:0]  normal_y,
    input  logic signed [NORM_W-1:0]  normal_z,
    input  logic signed [COORD_W-1:0] plane_offset,
    input  logic signed [COORD_W-1:0] point_x,
    input  logic signed [COORD_W-1:0] point_y,
    input  logic signed [COORD_W-1:0] point_z,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [LEAF_W-1:0]         leaf_index,
    output logic [STEPS_W-1:0]        steps_taken,
    output logic                      walk_fault
);

    localparam int NODE_AW  = $clog2(NODE_COUNT);
    localparam int PLANE_AW = $clog2(PLANE_COUNT);
    localparam int STEP_W   = $clog2(MAX_DEPTH + 1);
    localparam int STEPS_MAX = (1 << STEPS_W) - 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_NODE  = 3'd1;
    localparam logic [2:0] ST_PLANE = 3'd2;
    localparam logic [2:0] ST_DIST  = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    node_entry_t  node_mem  [NODE_COUNT];
    plane_entry_t plane_mem [PLANE_COUNT];

    logic [2:0]                state_reg, state_next;
    logic [NODE_AW-1:0]        idx_reg, idx_next;
    logic [STEP_W-1:0]         steps_reg, steps_next;
    logic signed [COORD_W-1:0] px_reg, py_reg, pz_reg;
    logic [IDX_W-1:0]          front_reg, back_reg;
    logic                      plane_ok_reg;
    logic                      dist_go_reg;
    logic [LEAF_W-1:0]         res_leaf_reg, res_leaf_next;
    logic                      res_fault_reg, res_fault_next;
    logic                      out_valid_reg, out_valid_next;
    logic [LEAF_W-1:0]         leaf_out_reg;
    logic [STEPS_W-1:0]        steps_out_reg;
    logic                      fault_out_reg;

    node_entry_t               node_rdata_reg;
    plane_entry_t              plane_rdata_reg;

    logic                      in_acc;
    logic [31:0]               slot32;
    logic                      node_we, plane_we, locate_go;
    logic                      node_re, plane_re;
    logic [NODE_AW-1:0]        node_addr;
    logic [PLANE_AW-1:0]       plane_addr;
    logic [31:0]               pref32;
    logic                      plane_ok;
    logic                      dist_done, dist_neg;
    logic [IDX_W-1:0]          child;
    logic [IDX_W-1:0]          leaf13;
    logic [31:0]               child32;
    logic [31:0]               leaf32;
    logic [STEP_W-1:0]         steps_inc;
    logic [31:0]               steps_inc32;
    logic [31:0]               steps32;
    logic [STEPS_W-1:0]        steps_sat;
    logic                      out_free;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign slot32   = {{(32 - IDX_W){1'b0}}, entry_index};
    assign pref32   = {{(32 - IDX_W){1'b0}}, node_rdata_reg.plane};
    assign plane_ok = pref32 < 32'(PLANE_COUNT);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        node_we   = 1'b0;
        plane_we  = 1'b0;
        locate_go = 1'b0;
        if (in_acc)
        begin
            case (opcode)
                OP_NODE_WR:  node_we   = slot32 < 32'(NODE_COUNT);
                OP_PLANE_WR: plane_we  = slot32 < 32'(PLANE_COUNT);
                OP_LOCATE:   locate_go = 1'b1;
                OP_NONE:     ;
                default:     ;
            endcase
        end
    end

    assign node_re    = (state_reg == ST_NODE);
    assign plane_re   = (state_reg == ST_PLANE);
    assign node_addr  = node_we ? slot32[NODE_AW-1:0] : idx_reg;
    assign plane_addr = plane_we ? slot32[PLANE_AW-1:0] : pref32[PLANE_AW-1:0];

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_addr] <= '{plane: plane_ref, front: front_child, back: back_child};
        end
        if (node_re)
        begin
            node_rdata_reg <= node_mem[node_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (plane_we)
        begin
            plane_mem[plane_addr] <= '{nx: normal_x, ny: normal_y, nz: normal_z,
                                       offset: plane_offset};
        end
        if (plane_re)
        begin
            plane_rdata_reg <= plane_mem[plane_addr];
        end
    end

    bspl_dist u_dist (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (dist_go_reg),
        .plane (plane_rdata_reg),
        .px    (px_reg),
        .py    (py_reg),
        .pz    (pz_reg),
        .done  (dist_done),
        .neg   (dist_neg)
    );

    always_comb
    begin
        child       = (plane_ok_reg && dist_neg) ? back_reg : front_reg;
        leaf13      = ~child;
        child32     = {{(32 - IDX_W){1'b0}}, child};
        leaf32      = {{(32 - IDX_W){1'b0}}, leaf13};
        steps_inc   = steps_reg + 1'b1;
        steps_inc32 = 32'(steps_inc);
        steps32     = 32'(steps_reg);
        steps_sat   = (steps32 > 32'(STEPS_MAX)) ? STEPS_W'(STEPS_MAX) : steps32[STEPS_W-1:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        steps_next     = steps_reg;
        res_leaf_next  = res_leaf_reg;
        res_fault_next = res_fault_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (locate_go)
                begin
                    idx_next   = '0;
                    steps_next = '0;
                    state_next = ST_NODE;
                end
            end
            ST_NODE:
            begin
                state_next = ST_PLANE;
            end
            ST_PLANE:
            begin
                state_next = ST_DIST;
            end
            ST_DIST:
            begin
                if (dist_done)
                begin
                    steps_next = steps_inc;
                    if (child[IDX_W-1])
                    begin
                        res_fault_next = leaf32 >= 32'(LEAF_COUNT);
                        res_leaf_next  = res_fault_next ? '0 : leaf13[LEAF_W-1:0];
                        state_next     = ST_FIN;
                    end
                    else if (steps_inc32 >= 32'(MAX_DEPTH) || child32 >= 32'(NODE_COUNT))
                    begin
                        res_fault_next = 1'b1;
                        res_leaf_next  = '0;
                        state_next     = ST_FIN;
                    end
                    else
                    begin
                        idx_next   = child32[NODE_AW-1:0];
                        state_next = ST_NODE;
                    end
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            dist_go_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            dist_go_reg   <= (state_reg == ST_PLANE);
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        steps_reg     <= steps_next;
        res_leaf_reg  <= res_leaf_next;
        res_fault_reg <= res_fault_next;
        if (locate_go)
        begin
            px_reg <= point_x;
            py_reg <= point_y;
            pz_reg <= point_z;
        end
        if (state_reg == ST_PLANE)
        begin
            front_reg    <= node_rdata_reg.front;
            back_reg     <= node_rdata_reg.back;
            plane_ok_reg <= plane_ok;
        end
        if (state_reg == ST_FIN && out_free)
        begin
            leaf_out_reg  <= res_leaf_reg;
            steps_out_reg <= steps_sat;
            fault_out_reg <= res_fault_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign leaf_index  = leaf_out_reg;
    assign steps_taken = steps_out_reg;
    assign walk_fault  = fault_out_reg;

    a_fault_zero_leaf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && walk_fault |-> leaf_index == '0)
        else $error("fault result with nonzero leaf");

    a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> 32'(steps_reg) <= 32'(MAX_DEPTH))
        else $error("step count beyond depth limit");

    a_dist_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        dist_done |-> state_reg == ST_DIST)
        else $error("distance result outside the wait state");

    a_locate_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && opcode == OP_LOCATE |=> state_reg == ST_NODE)
        else $error("locate did not start a node read");

    a_fin_holds_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIN && out_valid_reg && out_stall |=> state_reg == ST_FIN)
        else $error("result left finish state while output was full");

endmodule

>>> sv/bspl_dist.sv
// Three-stage signed plane distance unit: products, partial sums, sign.
// Reports only whether dot(normal, point) - offset * 2^14 is negative.
// Depends on bspl_pkg.
module bspl_dist
    import bspl_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      go,
    input  plane_entry_t              plane,
    input  logic signed [COORD_W-1:0] px,
    input  logic signed [COORD_W-1:0] py,
    input  logic signed [COORD_W-1:0] pz,
    output logic                      done,
    output logic                      neg
);

    logic                      s1_vld_reg;
    logic                      s2_vld_reg;
    logic                      done_reg;
    logic signed [PROD_W-1:0]  prod_x_reg;
    logic signed [PROD_W-1:0]  prod_y_reg;
    logic signed [PROD_W-1:0]  prod_z_reg;
    logic signed [COORD_W-1:0] off_reg;
    logic signed [DIST_W-1:0]  sum_a_reg;
    logic signed [DIST_W-1:0]  sum_b_reg;
    logic                      neg_reg;

    logic signed [PROD_W-1:0]  prod_x_next;
    logic signed [PROD_W-1:0]  prod_y_next;
    logic signed [PROD_W-1:0]  prod_z_next;
    logic signed [DIST_W-1:0]  sum_a_next;
    logic signed [DIST_W-1:0]  sum_b_next;
    logic signed [DIST_W-1:0]  total;

    always_comb
    begin
        prod_x_next = PROD_W'($signed(plane.nx)) * PROD_W'(px);
        prod_y_next = PROD_W'($signed(plane.ny)) * PROD_W'(py);
        prod_z_next = PROD_W'($signed(plane.nz)) * PROD_W'(pz);
        sum_a_next  = DIST_W'(prod_x_reg) + DIST_W'(prod_y_reg);
        sum_b_next  = DIST_W'(prod_z_reg) - (DIST_W'(off_reg) <<< OFF_SHIFT);
        total       = sum_a_reg + sum_b_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= go;
            s2_vld_reg <= s1_vld_reg;
            done_reg   <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
            prod_z_reg <= prod_z_next;
            off_reg    <= $signed(plane.offset);
        end
        if (s1_vld_reg)
        begin
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
        end
        if (s2_vld_reg)
        begin
            neg_reg <= total[DIST_W-1];
        end
    end

    assign done = done_reg;
    assign neg  = neg_reg;

endmodule

>>> tb/tb_bsp_point_leaf_locator_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for bsp_point_leaf_locator_top: loads node and plane tables,
// walks points through the tree and checks every result word against its own tree walker.
// Depends on bspl_pkg and the locator RTL.
module tb_bsp_point_leaf_locator_top
    import bspl_pkg::*;
;

    localparam int RAND_WORDS = 1200;
    localparam int SQUEEZE_AT = 300;
    localparam int SQUEEZE_CYCLES = 1500;
    localparam int DRAIN_CYCLES = 6 * DEF_MAX_DEPTH + 20;
    localparam int NODE_AW = $clog2(DEF_NODE_COUNT);
    localparam int PLANE_AW = $clog2(DEF_PLANE_COUNT);

    typedef struct {
        logic [OP_W-1:0]           op;
        logic [IDX_W-1:0]          slot;
        logic [IDX_W-1:0]          pref;
        logic signed [IDX_W-1:0]   front;
        logic signed [IDX_W-1:0]   back;
        logic signed [NORM_W-1:0]  nx;
        logic signed [NORM_W-1:0]  ny;
        logic signed [NORM_W-1:0]  nz;
        logic signed [COORD_W-1:0] offs;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
    } stim_word_t;

    typedef struct {
        logic [LEAF_W-1:0]  leaf;
        logic [STEPS_W-1:0] steps;
        logic               fault;
    } leaf_result_t;

    class leaf_walk_board;
        logic [IDX_W-1:0]          node_plane [DEF_NODE_COUNT];
        logic signed [IDX_W-1:0]   node_front [DEF_NODE_COUNT];
        logic signed [IDX_W-1:0]   node_back  [DEF_NODE_COUNT];
        logic signed [NORM_W-1:0]  plane_nx   [DEF_PLANE_COUNT];
        logic signed [NORM_W-1:0]  plane_ny   [DEF_PLANE_COUNT];
        logic signed [NORM_W-1:0]  plane_nz   [DEF_PLANE_COUNT];
        logic signed [COORD_W-1:0] plane_off  [DEF_PLANE_COUNT];
        leaf_result_t pending_leaves [$];
        int errors;
        int walks;
        int faults;
        int deepest;

        function void walk_point(stim_word_t w);
            int idx;
            int steps;
            int leaf;
            int p;
            bit fault;
            bit done;
            longint plane_dist;
            leaf_result_t r;
            idx = 0;
            steps = 0;
            leaf = 0;
            fault = 1'b0;
            done = 1'b0;
            while (!done) begin
                if (idx < 0) begin
                    leaf = -idx - 1;
                    if (leaf >= DEF_LEAF_COUNT)
                        fault = 1'b1;
                    done = 1'b1;
                end
                else if (steps >= DEF_MAX_DEPTH || idx >= DEF_NODE_COUNT) begin
                    fault = 1'b1;
                    done = 1'b1;
                end
                else begin
                    p = int'(node_plane[NODE_AW'(idx)]);
                    plane_dist = 0;
                    steps++;
                    if (p < DEF_PLANE_COUNT)
                        plane_dist = longint'(plane_nx[PLANE_AW'(p)]) * longint'(w.px)
                                   + longint'(plane_ny[PLANE_AW'(p)]) * longint'(w.py)
                                   + longint'(plane_nz[PLANE_AW'(p)]) * longint'(w.pz)
                                   - longint'(plane_off[PLANE_AW'(p)])
                                     * (longint'(1) << OFF_SHIFT);
                    idx = (plane_dist >= 0) ? int'(node_front[NODE_AW'(idx)])
                                            : int'(node_back[NODE_AW'(idx)]);
                end
            end
            if (fault)
                leaf = 0;
            r.leaf = LEAF_W'(leaf);
            r.steps = STEPS_W'(steps);
            r.fault = fault;
            walks++;
            if (fault)
                faults++;
            if (steps > deepest)
                deepest = steps;
            pending_leaves = {pending_leaves, r};
        endfunction

        function void note_word(stim_word_t w);
            case (w.op)
                OP_NODE_WR:
                    if (w.slot < DEF_NODE_COUNT) begin
                        node_plane[w.slot[NODE_AW-1:0]] = w.pref;
                        node_front[w.slot[NODE_AW-1:0]] = w.front;
                        node_back[w.slot[NODE_AW-1:0]] = w.back;
                    end
                OP_PLANE_WR:
                    if (w.slot < DEF_PLANE_COUNT) begin
                        plane_nx[w.slot[PLANE_AW-1:0]] = w.nx;
                        plane_ny[w.slot[PLANE_AW-1:0]] = w.ny;
                        plane_nz[w.slot[PLANE_AW-1:0]] = w.nz;
                        plane_off[w.slot[PLANE_AW-1:0]] = w.offs;
                    end
                OP_LOCATE:
                    walk_point(w);
                default: ;
            endcase
        endfunction

        function void check_word(logic [LEAF_W-1:0] leaf, logic [STEPS_W-1:0] steps,
                                 logic fault);
            leaf_result_t e;
            if (pending_leaves.size() == 0) begin
                errors++;
                $display("%t: unexpected word, leaf_index %0d steps_taken %0d walk_fault %0b",
                         $time, leaf, steps, fault);
                return;
            end
            e = pending_leaves.pop_front();
            if (leaf !== e.leaf) begin
                errors++;
                $display("%t: leaf_index expected %0d actual %0d", $time, e.leaf, leaf);
            end
            if (steps !== e.steps) begin
                errors++;
                $display("%t: steps_taken expected %0d actual %0d", $time, e.steps, steps);
            end
            if (fault !== e.fault) begin
                errors++;
                $display("%t: walk_fault expected %0b actual %0b", $time, e.fault, fault);
            end
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic [OP_W-1:0]           opcode;
    logic [IDX_W-1:0]          entry_index;
    logic [IDX_W-1:0]          plane_ref;
    logic signed [IDX_W-1:0]   front_child;
    logic signed [IDX_W-1:0]   back_child;
    logic signed [NORM_W-1:0]  normal_x;
    logic signed [NORM_W-1:0]  normal_y;
    logic signed [NORM_W-1:0]  normal_z;
    logic signed [COORD_W-1:0] plane_offset;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic                      out_valid;
    logic                      out_stall;
    logic [LEAF_W-1:0]         leaf_index;
    logic [STEPS_W-1:0]        steps_taken;
    logic                      walk_fault;

    leaf_walk_board board;
    bit   node_live  [DEF_NODE_COUNT];
    bit   plane_live [DEF_PLANE_COUNT];
    int   live_nodes [$];
    int   live_planes [$];
    int   last_node = -1;
    int   node_writes;
    int   plane_writes;
    bit   tx_idle_on = 1'b1;
    bit   squeeze_go;
    bit   squeeze_done;
    int   hold_left;
    int   rx_cycle;

    bsp_point_leaf_locator_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .entry_index  (entry_index),
        .plane_ref    (plane_ref),
        .front_child  (front_child),
        .back_child   (back_child),
        .normal_x     (normal_x),
        .normal_y     (normal_y),
        .normal_z     (normal_z),
        .plane_offset (plane_offset),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_z      (point_z),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .leaf_index   (leaf_index),
        .steps_taken  (steps_taken),
        .walk_fault   (walk_fault)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic stim_word_t rand_word();
        stim_word_t w;
        w.op = OP_NONE;
        w.slot = IDX_W'($urandom);
        w.pref = IDX_W'($urandom);
        w.front = IDX_W'($urandom);
        w.back = IDX_W'($urandom);
        w.nx = NORM_W'($urandom);
        w.ny = NORM_W'($urandom);
        w.nz = NORM_W'($urandom);
        w.offs = COORD_W'($urandom);
        w.px = COORD_W'($urandom);
        w.py = COORD_W'($urandom);
        w.pz = COORD_W'($urandom);
        return w;
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_coord();
        case ($urandom_range(9))
            0: return {1'b1, {(COORD_W-1){1'b0}}};
            1: return {1'b0, {(COORD_W-1){1'b1}}};
            2: return '0;
            3: return $signed(COORD_W'(int'($urandom_range(8)) - 4));
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [NORM_W-1:0] pick_norm();
        case ($urandom_range(9))
            0: return {1'b1, {(NORM_W-1){1'b0}}};
            1: return {1'b0, {(NORM_W-1){1'b1}}};
            2: return '0;
            default: return NORM_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [IDX_W-1:0] pick_child();
        int r;
        int v;
        r = $urandom_range(99);
        if (r < 35)
            v = -int'($urandom_range(DEF_LEAF_COUNT, 1));
        else if (r < 90 && last_node >= 0)
            v = last_node;
        else
            v = live_nodes[$urandom_range(live_nodes.size() - 1)];
        return v[IDX_W-1:0];
    endfunction

    task automatic send_word(input stim_word_t w);
        while (tx_idle_on && $urandom_range(99) < 37) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= w.op;
        entry_index <= w.slot;
        plane_ref <= w.pref;
        front_child <= w.front;
        back_child <= w.back;
        normal_x <= w.nx;
        normal_y <= w.ny;
        normal_z <= w.nz;
        plane_offset <= w.offs;
        point_x <= w.px;
        point_y <= w.py;
        point_z <= w.pz;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_word(w);
    endtask

    task automatic put_node(input int slot, input logic [IDX_W-1:0] pref,
                            input logic signed [IDX_W-1:0] front,
                            input logic signed [IDX_W-1:0] back);
        stim_word_t w;
        w = rand_word();
        w.op = OP_NODE_WR;
        w.slot = IDX_W'(slot);
        w.pref = pref;
        w.front = front;
        w.back = back;
        send_word(w);
        node_writes++;
        if (slot < DEF_NODE_COUNT) begin
            if (!node_live[NODE_AW'(slot)])
                live_nodes = {live_nodes, slot};
            node_live[NODE_AW'(slot)] = 1'b1;
            last_node = slot;
        end
    endtask

    task automatic put_plane(input int slot, input logic signed [NORM_W-1:0] nx,
                             input logic signed [NORM_W-1:0] ny,
                             input logic signed [NORM_W-1:0] nz,
                             input logic signed [COORD_W-1:0] offs);
        stim_word_t w;
        w = rand_word();
        w.op = OP_PLANE_WR;
        w.slot = IDX_W'(slot);
        w.nx = nx;
        w.ny = ny;
        w.nz = nz;
        w.offs = offs;
        send_word(w);
        plane_writes++;
        if (!plane_live[PLANE_AW'(slot)])
            live_planes = {live_planes, slot};
        plane_live[PLANE_AW'(slot)] = 1'b1;
    endtask

    task automatic put_locate(input logic signed [COORD_W-1:0] px,
                              input logic signed [COORD_W-1:0] py,
                              input logic signed [COORD_W-1:0] pz);
        stim_word_t w;
        w = rand_word();
        w.op = OP_LOCATE;
        w.px = px;
        w.py = py;
        w.pz = pz;
        send_word(w);
    endtask

    task automatic put_none();
        stim_word_t w;
        w = rand_word();
        w.op = OP_NONE;
        send_word(w);
    endtask

    task automatic random_node();
        int s;
        int slot;
        s = $urandom_range(99);
        if (s < 5)
            slot = 0;
        else if (s < 65)
            slot = $urandom_range(63);
        else if (s < 85)
            slot = $urandom_range(DEF_NODE_COUNT - 1);
        else
            slot = $urandom_range((1 << IDX_W) - 1, DEF_NODE_COUNT);
        put_node(slot, IDX_W'(live_planes[$urandom_range(live_planes.size() - 1)]),
                 pick_child(), pick_child());
    endtask

    task automatic random_plane();
        int slot;
        slot = ($urandom_range(1) != 0) ? $urandom_range(31) : $urandom_range(DEF_PLANE_COUNT - 1);
        if ($urandom_range(9) == 0)
            put_plane(slot, '0, '0, '0, '0);
        else
            put_plane(slot, pick_norm(), pick_norm(), pick_norm(), pick_coord());
    endtask

    initial begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        opcode <= OP_NONE;
        entry_index <= '0;
        plane_ref <= '0;
        front_child <= '0;
        back_child <= '0;
        normal_x <= '0;
        normal_y <= '0;
        normal_z <= '0;
        plane_offset <= '0;
        point_x <= '0;
        point_y <= '0;
        point_z <= '0;
        board = new();
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        put_plane(0, 16'sd16384, '0, '0, '0);
        put_plane(DEF_PLANE_COUNT - 1, 16'sh8000, 16'sh8000, 16'sh8000, 32'sh8000_0000);
        put_plane(1, 16'sh7fff, 16'sh7fff, 16'sh7fff, 32'sh7fff_ffff);
        put_node(0, 0, -13'sd1, -13'sd4096);
        put_locate('0, '0, '0);
        put_locate(-32'sd1, '0, '0);
        put_none();
        put_node(DEF_NODE_COUNT - 1, IDX_W'(DEF_PLANE_COUNT - 1), -13'sd2, -13'sd3);
        put_node(0, 1, 13'sd4095, -13'sd5);
        put_locate(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        put_locate(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
        put_node(5000, 0, '0, '0);
        put_locate(32'sh7fff_ffff, '0, 32'sh8000_0000);
        put_node(0, 0, '0, '0);
        put_locate(32'sd1, 32'sd2, 32'sd3);
        put_node(0, 0, 13'sd4095, -13'sd4096);
        put_locate('0, '0, '0);
        put_locate(-32'sd65536, 32'sd65536, '0);

        for (int k = 0; k < RAND_WORDS; k++) begin
            int r;
            if (k == SQUEEZE_AT)
                squeeze_go = 1'b1;
            tx_idle_on = !(k >= 500 && k < 700);
            r = $urandom_range(99);
            if (r < 35)
                random_node();
            else if (r < 55)
                random_plane();
            else if (r < 95)
                put_locate(pick_coord(), pick_coord(), pick_coord());
            else
                put_none();
        end
        in_valid <= 1'b0;

        while (board.pending_leaves.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Walked %0d points (%0d depth faults, deepest walk %0d nodes)",
                 board.walks, board.faults, board.deepest);
        $display("after %0d node writes and %0d plane writes, with stalls on both sides",
                 node_writes, plane_writes);
        if (board.errors == 0 && board.pending_leaves.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            rx_cycle++;
            if (rst_n && out_valid && !out_stall)
                board.check_word(leaf_index, steps_taken, walk_fault);
            if (squeeze_go && !squeeze_done) begin
                hold_left = SQUEEZE_CYCLES;
                squeeze_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (rx_cycle >= 15000 && rx_cycle < 25000)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < 37);
        end
    end

    initial begin
        #30_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
